// File: hw/rtl/sfm_pkg.sv
// Shared constants, types and the rounded Q multiply for the Fresnel modulator.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package sfm_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_EXPONENT_DEF = 10;

    // exponent registers are 4 bits; effective exponent needs one more bit
    localparam int EXP_W       = 4;
    localparam int CFG_INDEX_W = 3;

    // operand width of the shared multiply; covers levels up to FRAC_BITS = 30
    localparam int QW = 32;

    localparam int F0_RESET  = 2621;
    localparam int EXP_RESET = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BASE_REFLECTANCE    = 3'd0,
        REG_REFLECT_EXPONENT    = 3'd1,
        REG_DIFFUSE_EXPONENT    = 3'd2,
        REG_ENABLE_MIRROR       = 3'd3,
        REG_ENABLE_TRANSPARENCY = 3'd4,
        REG_ENABLE_DIFFUSE      = 3'd5
    } cfg_reg_t;

    // clamped exponents handed to the power chain
    typedef struct packed {
        logic [EXP_W:0] reflect_n;
        logic [EXP_W:0] diffuse_n;
    } exp_cfg_t;

    // (a * b + half) >> frac, round to nearest, ties up
    function automatic logic [QW-1:0] qmul(input logic [QW-1:0] a,
                                           input logic [QW-1:0] b,
                                           input int frac);
        logic [2*QW-1:0] prod;
        prod = (2*QW)'(a) * (2*QW)'(b) + ((2*QW)'(1) << (frac - 1));
        return QW'(prod >> frac);
    endfunction

endpackage

// File: hw/rtl/sfm_in_if.sv
// Input channel of the Fresnel modulator: valid/ready plus one shading sample.
// Depends on sfm_pkg for the default fraction width.
`timescale 1ns / 1ps

interface sfm_in_if #(
    parameter int FRAC_BITS = sfm_pkg::FRAC_BITS_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic signed [FRAC_BITS+1:0] view_cosine;
    logic        [FRAC_BITS:0]   mirror_in;
    logic        [FRAC_BITS:0]   transparency_in;
    logic        [FRAC_BITS:0]   diffuse_in;

    modport source (
        output valid, view_cosine, mirror_in, transparency_in, diffuse_in,
        input  ready
    );
    modport sink (
        input  valid, view_cosine, mirror_in, transparency_in, diffuse_in,
        output ready
    );
endinterface

// File: hw/rtl/sfm_out_if.sv
// Output channel of the Fresnel modulator: valid/ready plus modulated levels.
// Depends on sfm_pkg for the default fraction width.
`timescale 1ns / 1ps

interface sfm_out_if #(
    parameter int FRAC_BITS = sfm_pkg::FRAC_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [FRAC_BITS:0]   mirror_out;
    logic [FRAC_BITS:0]   transparency_out;
    logic [FRAC_BITS:0]   diffuse_out;

    modport source (
        output valid, mirror_out, transparency_out, diffuse_out,
        input  ready
    );
    modport sink (
        input  valid, mirror_out, transparency_out, diffuse_out,
        output ready
    );
endinterface

// File: hw/rtl/sfm_power_chain.sv
// Pipelined power unit: raises m to the reflect and diffuse exponents,
// one rounded multiply per exponent per stage, levels carried alongside. Uses sfm_pkg.
`timescale 1ns / 1ps

module sfm_power_chain #(
    parameter int FRAC_BITS    = sfm_pkg::FRAC_BITS_DEF,
    parameter int MAX_EXPONENT = sfm_pkg::MAX_EXPONENT_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sfm_pkg::exp_cfg_t         exps,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [FRAC_BITS:0]        in_m,
    input  logic [3*(FRAC_BITS+1)-1:0] in_lev,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [FRAC_BITS:0]        out_pr,
    output logic [FRAC_BITS:0]        out_pd,
    output logic [3*(FRAC_BITS+1)-1:0] out_lev
);

    localparam int L   = FRAC_BITS + 1;
    localparam int NST = MAX_EXPONENT - 1;
    localparam int NSZ = (NST > 0) ? NST : 1;

    logic           v_reg   [NSZ];
    logic [L-1:0]   m_reg   [NSZ];
    logic [L-1:0]   pr_reg  [NSZ];
    logic [L-1:0]   pd_reg  [NSZ];
    logic [3*L-1:0] lev_reg [NSZ];
    logic           en      [NSZ];

    if (NST == 0) begin : g_none
        // m^1 is m itself: nothing to multiply
        assign in_ready  = out_ready;
        assign out_valid = in_valid;
        assign out_pr    = in_m;
        assign out_pd    = in_m;
        assign out_lev   = in_lev;
        assign en[0]     = 1'b0;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[0] <= 1'b0;
            end
            else
            begin
                v_reg[0] <= 1'b0;
            end
        end
        always_ff @(posedge clk)
        begin
            m_reg[0]   <= in_m;
            pr_reg[0]  <= in_m;
            pd_reg[0]  <= in_m;
            lev_reg[0] <= in_lev;
        end
    end
    else begin : g_chain
        assign in_ready  = en[0];
        assign out_valid = v_reg[NST-1];
        assign out_pr    = pr_reg[NST-1];
        assign out_pd    = pd_reg[NST-1];
        assign out_lev   = lev_reg[NST-1];

        for (genvar k = 0; k < NST; k++) begin : g_st
            logic                v_src;
            logic [L-1:0]        m_src;
            logic [L-1:0]        pr_src;
            logic [L-1:0]        pd_src;
            logic [3*L-1:0]      lev_src;
            logic                nxt_en;
            logic [sfm_pkg::QW-1:0] pr_mul;
            logic [sfm_pkg::QW-1:0] pd_mul;
            logic [L-1:0]        pr_next;
            logic [L-1:0]        pd_next;

            if (k == 0) begin : g_head
                // p starts at m: the first power needs no multiply
                assign v_src   = in_valid;
                assign m_src   = in_m;
                assign pr_src  = in_m;
                assign pd_src  = in_m;
                assign lev_src = in_lev;
            end
            else begin : g_body
                assign v_src   = v_reg[k-1];
                assign m_src   = m_reg[k-1];
                assign pr_src  = pr_reg[k-1];
                assign pd_src  = pd_reg[k-1];
                assign lev_src = lev_reg[k-1];
            end

            if (k == NST - 1) begin : g_tail
                assign nxt_en = out_ready;
            end
            else begin : g_mid
                assign nxt_en = en[k+1];
            end

            assign en[k] = !v_reg[k] || nxt_en;

            assign pr_mul = sfm_pkg::qmul(sfm_pkg::QW'(pr_src), sfm_pkg::QW'(m_src),
                                          FRAC_BITS);
            assign pd_mul = sfm_pkg::qmul(sfm_pkg::QW'(pd_src), sfm_pkg::QW'(m_src),
                                          FRAC_BITS);

            // this stage forms power k+2 when the exponent reaches it
            assign pr_next = (exps.reflect_n > (sfm_pkg::EXP_W+1)'(k + 1))
                             ? pr_mul[L-1:0] : pr_src;
            assign pd_next = (exps.diffuse_n > (sfm_pkg::EXP_W+1)'(k + 1))
                             ? pd_mul[L-1:0] : pd_src;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    v_reg[k] <= v_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    m_reg[k]   <= m_src;
                    pr_reg[k]  <= pr_next;
                    pd_reg[k]  <= pd_next;
                    lev_reg[k] <= lev_src;
                end
            end
        end
    end

endmodule

// File: hw/rtl/schlick_fresnel_surface_modulator.sv
// Throughput: one item per cycle unless result.ready stalls the output; the power
// chain has MAX_EXPONENT - 1 multiply stages, one multiply per chain per stage, plus
// clamp, Schlick and output stages. Each stage holds its item under back-pressure
// and fills whenever it is empty.
// Reset empties the pipeline and loads the register defaults (f0 2621, exponents 5,
// all channels enabled). Top level; uses sfm_pkg, sfm_in_if, sfm_out_if, sfm_power_chain.
`timescale 1ns / 1ps

module schlick_fresnel_surface_modulator #(
    parameter int FRAC_BITS    = sfm_pkg::FRAC_BITS_DEF,
    parameter int MAX_EXPONENT = sfm_pkg::MAX_EXPONENT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [sfm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [FRAC_BITS:0]              cfg_data,
    sfm_in_if.sink                          sample,
    sfm_out_if.source                       result
);

    localparam int L = FRAC_BITS + 1;
    localparam int C = FRAC_BITS + 2;
    localparam int EW = sfm_pkg::EXP_W;
    localparam logic [L-1:0] ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [C-1:0] ONE_C = {2'b01, {FRAC_BITS{1'b0}}};

    // ---------------- configuration registers ----------------
    logic [L-1:0]  base_reflectance_reg;
    logic [EW-1:0] reflect_exponent_reg;
    logic [EW-1:0] diffuse_exponent_reg;
    logic          enable_mirror_reg;
    logic          enable_transparency_reg;
    logic          enable_diffuse_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reflectance_reg    <= L'(sfm_pkg::F0_RESET);
            reflect_exponent_reg    <= EW'(sfm_pkg::EXP_RESET);
            diffuse_exponent_reg    <= EW'(sfm_pkg::EXP_RESET);
            enable_mirror_reg       <= 1'b1;
            enable_transparency_reg <= 1'b1;
            enable_diffuse_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfm_pkg::REG_BASE_REFLECTANCE:    base_reflectance_reg    <= cfg_data;
                sfm_pkg::REG_REFLECT_EXPONENT:    reflect_exponent_reg    <= cfg_data[EW-1:0];
                sfm_pkg::REG_DIFFUSE_EXPONENT:    diffuse_exponent_reg    <= cfg_data[EW-1:0];
                sfm_pkg::REG_ENABLE_MIRROR:       enable_mirror_reg       <= cfg_data[0];
                sfm_pkg::REG_ENABLE_TRANSPARENCY: enable_transparency_reg <= cfg_data[0];
                sfm_pkg::REG_ENABLE_DIFFUSE:      enable_diffuse_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // exponent 0 acts as 1, anything above MAX_EXPONENT as MAX_EXPONENT
    sfm_pkg::exp_cfg_t exps;

    function automatic logic [EW:0] clamp_exp(input logic [EW-1:0] e);
        logic [EW:0] ext;
        ext = {1'b0, e};
        if (ext == '0)
            return (EW+1)'(1);
        else if (ext > (EW+1)'(MAX_EXPONENT))
            return (EW+1)'(MAX_EXPONENT);
        else
            return ext;
    endfunction

    assign exps.reflect_n = clamp_exp(reflect_exponent_reg);
    assign exps.diffuse_n = clamp_exp(diffuse_exponent_reg);

    // ---------------- stage A: |cos| clamp, level clamp ----------------
    logic           a_v_reg;
    logic [L-1:0]   a_m_reg;
    logic [3*L-1:0] a_lev_reg;
    logic           a_en;
    logic           chain_in_ready;

    logic [C-1:0]   cos_raw;
    logic [C-1:0]   cos_mag;
    logic [L-1:0]   cos_sat;
    logic [L-1:0]   m_next;
    logic [L-1:0]   mir_next;
    logic [L-1:0]   tra_next;
    logic [L-1:0]   dif_next;

    always_comb
    begin
        cos_raw = sample.view_cosine;
        // most negative code negates to itself, which reads as 2.0 and clamps
        cos_mag = cos_raw[C-1] ? (~cos_raw + C'(1)) : cos_raw;
        cos_sat = (cos_mag > ONE_C) ? ONE : cos_mag[L-1:0];
        m_next  = ONE - cos_sat;
        mir_next = (enable_mirror_reg && sample.mirror_in > ONE) ? ONE : sample.mirror_in;
        tra_next = (enable_transparency_reg && sample.transparency_in > ONE)
                   ? ONE : sample.transparency_in;
        dif_next = (enable_diffuse_reg && sample.diffuse_in > ONE) ? ONE : sample.diffuse_in;
    end

    assign a_en         = !a_v_reg || chain_in_ready;
    assign sample.ready = a_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
        end
        else if (a_en)
        begin
            a_v_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_en)
        begin
            a_m_reg   <= m_next;
            a_lev_reg <= {mir_next, tra_next, dif_next};
        end
    end

    // ---------------- power chain ----------------
    logic           p_v;
    logic           s_en;
    logic [L-1:0]   p_pr;
    logic [L-1:0]   p_pd;
    logic [3*L-1:0] p_lev;

    sfm_power_chain #(
        .FRAC_BITS    (FRAC_BITS),
        .MAX_EXPONENT (MAX_EXPONENT)
    ) u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .exps      (exps),
        .in_valid  (a_v_reg),
        .in_ready  (chain_in_ready),
        .in_m      (a_m_reg),
        .in_lev    (a_lev_reg),
        .out_valid (p_v),
        .out_ready (s_en),
        .out_pr    (p_pr),
        .out_pd    (p_pd),
        .out_lev   (p_lev)
    );

    // ---------------- stage S: F = f0 + (1 - f0) * p ----------------
    logic           s_v_reg;
    logic [L-1:0]   s_fr_reg;
    logic [L-1:0]   s_fd_reg;
    logic [3*L-1:0] s_lev_reg;
    logic           o_en;

    logic [L-1:0]          f0_sat;
    logic [sfm_pkg::QW-1:0] fr_mul;
    logic [sfm_pkg::QW-1:0] fd_mul;
    logic [L:0]            fr_sum;
    logic [L:0]            fd_sum;
    logic [L-1:0]          fr_next;
    logic [L-1:0]          fd_next;

    always_comb
    begin
        f0_sat  = (base_reflectance_reg > ONE) ? ONE : base_reflectance_reg;
        fr_mul  = sfm_pkg::qmul(sfm_pkg::QW'(ONE - f0_sat), sfm_pkg::QW'(p_pr), FRAC_BITS);
        fd_mul  = sfm_pkg::qmul(sfm_pkg::QW'(ONE - f0_sat), sfm_pkg::QW'(p_pd), FRAC_BITS);
        fr_sum  = {1'b0, f0_sat} + {1'b0, fr_mul[L-1:0]};
        fd_sum  = {1'b0, f0_sat} + {1'b0, fd_mul[L-1:0]};
        fr_next = (fr_sum > {1'b0, ONE}) ? ONE : fr_sum[L-1:0];
        fd_next = (fd_sum > {1'b0, ONE}) ? ONE : fd_sum[L-1:0];
    end

    assign s_en = !s_v_reg || o_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_v_reg <= 1'b0;
        end
        else if (s_en)
        begin
            s_v_reg <= p_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_en)
        begin
            s_fr_reg  <= fr_next;
            s_fd_reg  <= fd_next;
            s_lev_reg <= p_lev;
        end
    end

    // ---------------- stage O: channel modulation, output register ----------------
    logic         o_v_reg;
    logic [L-1:0] o_mir_reg;
    logic [L-1:0] o_tra_reg;
    logic [L-1:0] o_dif_reg;

    logic [L-1:0]           lv_mir;
    logic [L-1:0]           lv_tra;
    logic [L-1:0]           lv_dif;
    logic [sfm_pkg::QW-1:0] mir_mul;
    logic [sfm_pkg::QW-1:0] tra_mul;
    logic [sfm_pkg::QW-1:0] dif_mul;
    logic [L-1:0]           mir_res;
    logic [L-1:0]           tra_res;
    logic [L-1:0]           dif_res;

    always_comb
    begin
        lv_mir  = s_lev_reg[3*L-1:2*L];
        lv_tra  = s_lev_reg[2*L-1:L];
        lv_dif  = s_lev_reg[L-1:0];
        mir_mul = sfm_pkg::qmul(sfm_pkg::QW'(ONE - lv_mir), sfm_pkg::QW'(s_fr_reg), FRAC_BITS);
        tra_mul = sfm_pkg::qmul(sfm_pkg::QW'(lv_tra), sfm_pkg::QW'(ONE - s_fr_reg), FRAC_BITS);
        dif_mul = sfm_pkg::qmul(sfm_pkg::QW'(lv_dif), sfm_pkg::QW'(ONE - s_fd_reg), FRAC_BITS);
        // mirror is raised toward one; the sum never passes one
        mir_res = enable_mirror_reg ? (lv_mir + mir_mul[L-1:0]) : lv_mir;
        tra_res = enable_transparency_reg ? tra_mul[L-1:0] : lv_tra;
        dif_res = enable_diffuse_reg ? dif_mul[L-1:0] : lv_dif;
    end

    assign o_en = !o_v_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_v_reg <= 1'b0;
        end
        else if (o_en)
        begin
            o_v_reg <= s_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_en)
        begin
            o_mir_reg <= mir_res;
            o_tra_reg <= tra_res;
            o_dif_reg <= dif_res;
        end
    end

    assign result.valid            = o_v_reg;
    assign result.mirror_out       = o_mir_reg;
    assign result.transparency_out = o_tra_reg;
    assign result.diffuse_out      = o_dif_reg;

    // ---------------- assertions ----------------
    // an empty output register must let ready through the whole pipe
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !o_v_reg |-> sample.ready)
        else $error("sample.ready low with output register empty");

    a_m_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_v_reg |-> (a_m_reg <= ONE))
        else $error("one minus cosine above one");

    a_fresnel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s_v_reg |-> (s_fr_reg <= ONE && s_fd_reg <= ONE))
        else $error("Fresnel term above one");

    // an item in stage S moves on unless the output holds a stalled result
    a_stage_s_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (s_v_reg && (!o_v_reg || result.ready)) |=> o_v_reg)
        else $error("item lost between Schlick and output stage");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the Schlick Fresnel surface modulator.
// Holds a fixed-point scoreboard that predicts each result item, plus the stimulus.
// Depends on sfm_pkg, sfm_in_if, sfm_out_if and the top-level RTL.
`timescale 1ns / 1ps

typedef struct packed {
    logic [sfm_pkg::FRAC_BITS_DEF+1:0] view_cosine;
    logic [sfm_pkg::FRAC_BITS_DEF:0]   mirror;
    logic [sfm_pkg::FRAC_BITS_DEF:0]   transparency;
    logic [sfm_pkg::FRAC_BITS_DEF:0]   diffuse;
} shade_sample_t;

typedef struct packed {
    logic [sfm_pkg::FRAC_BITS_DEF:0] mirror;
    logic [sfm_pkg::FRAC_BITS_DEF:0] transparency;
    logic [sfm_pkg::FRAC_BITS_DEF:0] diffuse;
} shade_levels_t;

class fresnel_scoreboard;
    localparam int FB       = sfm_pkg::FRAC_BITS_DEF;
    localparam int MAX_EXP  = sfm_pkg::MAX_EXPONENT_DEF;
    localparam int COS_BITS = FB + 2;
    localparam longint unsigned ONE  = 64'd1 << FB;
    localparam longint unsigned HALF = 64'd1 << (FB - 1);

    logic [FB:0]               f0_reg;
    logic [sfm_pkg::EXP_W-1:0] refl_exp;
    logic [sfm_pkg::EXP_W-1:0] diff_exp;
    bit                        en_mir;
    bit                        en_tra;
    bit                        en_dif;
    shade_levels_t             levels_q[$];
    int                        mismatches;

    function new();
        f0_reg     = (FB+1)'(sfm_pkg::F0_RESET);
        refl_exp   = sfm_pkg::EXP_W'(sfm_pkg::EXP_RESET);
        diff_exp   = sfm_pkg::EXP_W'(sfm_pkg::EXP_RESET);
        en_mir     = 1'b1;
        en_tra     = 1'b1;
        en_dif     = 1'b1;
        mismatches = 0;
    endfunction

    function void set_reg(logic [sfm_pkg::CFG_INDEX_W-1:0] idx, logic [FB:0] data);
        case (idx)
            sfm_pkg::REG_BASE_REFLECTANCE:    f0_reg   = data;
            sfm_pkg::REG_REFLECT_EXPONENT:    refl_exp = data[sfm_pkg::EXP_W-1:0];
            sfm_pkg::REG_DIFFUSE_EXPONENT:    diff_exp = data[sfm_pkg::EXP_W-1:0];
            sfm_pkg::REG_ENABLE_MIRROR:       en_mir   = data[0];
            sfm_pkg::REG_ENABLE_TRANSPARENCY: en_tra   = data[0];
            sfm_pkg::REG_ENABLE_DIFFUSE:      en_dif   = data[0];
            default: ;  // unused index, write dropped
        endcase
    endfunction

    function longint unsigned round_mul(longint unsigned a, longint unsigned b);
        return (a * b + HALF) >> FB;
    endfunction

    function longint unsigned clamp_one(longint unsigned v);
        return (v > ONE) ? ONE : v;
    endfunction

    function longint unsigned fresnel_term(longint unsigned m,
                                           logic [sfm_pkg::EXP_W-1:0] expo);
        int n;
        longint unsigned p;
        longint unsigned f0;
        n = int'(expo);
        if (n < 1) n = 1;
        if (n > MAX_EXP) n = MAX_EXP;
        p  = ONE;
        f0 = clamp_one(64'(f0_reg));
        for (int i = 0; i < n; i++)
            p = round_mul(p, m);
        return clamp_one(f0 + round_mul(ONE - f0, p));
    endfunction

    function void note_sample(shade_sample_t s);
        longint unsigned raw, mag, m, mir, tra, dif, f, fd, v;
        shade_levels_t   r;
        raw = 64'(s.view_cosine);
        if (raw[COS_BITS-1])
            mag = (64'd1 << COS_BITS) - raw;
        else
            mag = raw;
        mag = clamp_one(mag);
        m   = ONE - mag;
        mir = 64'(s.mirror);
        tra = 64'(s.transparency);
        dif = 64'(s.diffuse);
        if (en_mir || en_tra)
        begin
            f = fresnel_term(m, refl_exp);
            if (en_mir)
            begin
                v   = clamp_one(mir);
                mir = v + round_mul(ONE - v, f);
            end
            if (en_tra)
                tra = round_mul(clamp_one(tra), ONE - f);
        end
        if (en_dif)
        begin
            fd  = fresnel_term(m, diff_exp);
            dif = round_mul(clamp_one(dif), ONE - fd);
        end
        r.mirror       = (FB+1)'(mir);
        r.transparency = (FB+1)'(tra);
        r.diffuse      = (FB+1)'(dif);
        levels_q.push_back(r);
    endfunction

    function void check_result(shade_levels_t got);
        shade_levels_t want;
        if (levels_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result item with nothing outstanding: mir %0d tra %0d dif %0d",
                         got.mirror, got.transparency, got.diffuse);
            return;
        end
        want = levels_q.pop_front();
        if (got.mirror !== want.mirror || got.transparency !== want.transparency ||
            got.diffuse !== want.diffuse)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: want mir %0d tra %0d dif %0d, got mir %0d tra %0d dif %0d",
                         want.mirror, want.transparency, want.diffuse,
                         got.mirror, got.transparency, got.diffuse);
        end
    endfunction

    function int pending();
        return levels_q.size();
    endfunction
endclass

module tb_top;

    localparam int  FB           = sfm_pkg::FRAC_BITS_DEF;
    localparam int  PIPE_LATENCY = sfm_pkg::MAX_EXPONENT_DEF + 2;
    localparam int  HOLD_CYCLES  = 120;
    localparam int  RAND_PHASES  = 10;
    localparam int  PHASE_ITEMS  = 70;
    localparam int  TIMEOUT_NS   = 5_000_000;
    // indexes past the end of the register map
    localparam logic [sfm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [sfm_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            cfg_we;
    logic [sfm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [FB:0]                     cfg_data;

    sfm_in_if  sample_ch ();
    sfm_out_if result_ch ();

    schlick_fresnel_surface_modulator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    fresnel_scoreboard sb = new();

    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;
    bit hold_result  = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    // long receiver hold-off, counted here so the sender keeps going
    initial
    begin
        forever
        begin
            wait (hold_request);
            hold_request = 1'b0;
            @(posedge clk);
            hold_result <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_result <= 1'b0;
        end
    end

    // result side: check each accepted item, then draw a stall for the next one
    initial
    begin
        int            stall;
        shade_levels_t got;
        stall = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
            begin
                got.mirror       = result_ch.mirror_out;
                got.transparency = result_ch.transparency_out;
                got.diffuse      = result_ch.diffuse_out;
                sb.check_result(got);
                stall = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (hold_result)
                result_ch.ready <= 1'b0;
            else if (stall > 0)
            begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // called in the step of a clock edge; returns in the step the item is taken
    task automatic drive_sample(input shade_sample_t s);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid           <= 1'b1;
        sample_ch.view_cosine     <= s.view_cosine;
        sample_ch.mirror_in       <= s.mirror;
        sample_ch.transparency_in <= s.transparency;
        sample_ch.diffuse_in      <= s.diffuse;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        sb.note_sample(s);
    endtask

    task automatic drain_results();
        sample_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sfm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [FB:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic configure(input logic [FB:0] f0, input int re, input int de,
                             input bit em, input bit et, input bit ed);
        write_reg(sfm_pkg::REG_BASE_REFLECTANCE, f0);
        write_reg(sfm_pkg::REG_REFLECT_EXPONENT, (FB+1)'(re));
        write_reg(sfm_pkg::REG_DIFFUSE_EXPONENT, (FB+1)'(de));
        write_reg(sfm_pkg::REG_ENABLE_MIRROR, (FB+1)'(em));
        write_reg(sfm_pkg::REG_ENABLE_TRANSPARENCY, (FB+1)'(et));
        write_reg(sfm_pkg::REG_ENABLE_DIFFUSE, (FB+1)'(ed));
        cfg_we <= 1'b0;
    endtask

    function automatic shade_sample_t corner_sample(int k);
        shade_sample_t s;
        case (k)
            0: s = '{18'(0), 17'd0, 17'd0, 17'd0};
            1: s = '{18'(65536), 17'd65536, 17'd65536, 17'd65536};
            2: s = '{18'(-65536), 17'd32768, 17'd40000, 17'd50000};
            3: s = '{18'(131071), 17'd131071, 17'd131071, 17'd131071};  // levels above one
            4: s = '{18'(-131072), 17'd70000, 17'd0, 17'd131071};
            5: s = '{18'(1), 17'd1, 17'd65535, 17'd12345};
            6: s = '{18'(-1), 17'd65535, 17'd1, 17'd65536};
            default: s = '{18'(65537), 17'h15555, 17'h0AAAA, 17'd65537};
        endcase
        return s;
    endfunction

    function automatic logic [FB:0] rand_level();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return (FB+1)'($urandom_range(0, 65536));
        else if (pick == 7)
            return $urandom_range(0, 1) ? 17'd65536 : 17'd0;
        return (FB+1)'($urandom);
    endfunction

    function automatic logic [FB+1:0] rand_cosine();
        int v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 131072) - 65536;
            2:
            begin
                // around magnitude one, either sign
                v = 65536 + $urandom_range(0, 8) - 4;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = $urandom_range(0, 511) - 256;
        endcase
        return (FB+2)'(v);
    endfunction

    initial
    begin
        shade_sample_t s;
        rst_n                     <= 1'b0;
        cfg_we                    <= 1'b0;
        cfg_index                 <= '0;
        cfg_data                  <= '0;
        sample_ch.valid           <= 1'b0;
        sample_ch.view_cosine     <= '0;
        sample_ch.mirror_in       <= '0;
        sample_ch.transparency_in <= '0;
        sample_ch.diffuse_in      <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (PIPE_LATENCY) @(posedge clk);

        // corners under the reset register values
        for (int k = 0; k < 8; k++)
            drive_sample(corner_sample(k));
        drain_results();

        // f0 above one, exponent zero and past the max, writes to unused indexes
        write_reg(sfm_pkg::REG_BASE_REFLECTANCE, 17'd131071);
        write_reg(sfm_pkg::REG_REFLECT_EXPONENT, 17'd0);
        write_reg(sfm_pkg::REG_DIFFUSE_EXPONENT, 17'd15);
        write_reg(CFG_UNUSED_LO, 17'h1FFFF);
        write_reg(CFG_UNUSED_HI, 17'd0);
        cfg_we <= 1'b0;
        for (int k = 0; k < 8; k++)
            drive_sample(corner_sample(k));
        drain_results();

        // disabled channels pass raw levels, even above one
        configure(17'd0, 1, 10, 1'b0, 1'b1, 1'b0);
        for (int k = 0; k < 8; k++)
            drive_sample(corner_sample(k));
        drain_results();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            case (ph)
                0: configure(17'd0, 1, 10, 1'b1, 1'b1, 1'b1);
                1: configure(17'd65536, 10, 1, 1'b1, 1'b1, 1'b1);
                2: configure(17'd131071, 0, 11, 1'b0, 1'b0, 1'b0);
                3: configure(17'(sfm_pkg::F0_RESET), 15, 0, 1'b1, 1'b0, 1'b1);
                default:
                    configure($urandom_range(0, 3) == 0 ? (FB+1)'($urandom)
                                                        : (FB+1)'($urandom_range(0, 65536)),
                              $urandom_range(0, 15), $urandom_range(0, 15),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
            endcase
            idle_on = (ph % 3 != 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (ph == 3 && i == 10)
                    hold_request = 1'b1;
                if (ph == 5 && i == PHASE_ITEMS / 2)
                    drain_results();
                s.view_cosine  = rand_cosine();
                s.mirror       = rand_level();
                s.transparency = rand_level();
                s.diffuse      = rand_level();
                drive_sample(s);
            end
            drain_results();
        end

        repeat (PIPE_LATENCY) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/sfm_pkg.sv
hw/rtl/sfm_in_if.sv
hw/rtl/sfm_out_if.sv
hw/rtl/sfm_power_chain.sv
hw/rtl/schlick_fresnel_surface_modulator.sv
tb/sv/tb_top.sv
